/* design/mrc_pkg.sv */
// shared types and constants of the modbus rtu response checker
package mrc_pkg;

	// request codes on the input side
	typedef enum logic [1:0] {
		CMD_ARM     = 2'd0,
		CMD_BYTE    = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	// receive phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RECV,
		PH_DONE
	} phase_t;

	// what the back end has to do with a queued request
	typedef enum logic [1:0] {
		RK_STATUS,
		RK_CHECK,
		RK_DATA
	} req_kind_t;

	// status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_TIMEOUT     = 4'd1;
	localparam logic [3:0] ST_CRC         = 4'd2;
	localparam logic [3:0] ST_SLAVE       = 4'd3;
	localparam logic [3:0] ST_FUNC        = 4'd4;
	localparam logic [3:0] ST_LENGTH      = 4'd5;
	localparam logic [3:0] ST_EXC_0A      = 4'd12;
	localparam logic [3:0] ST_EXC_0B      = 4'd13;
	localparam logic [3:0] ST_EXC_UNKNOWN = 4'd14;
	localparam logic [3:0] ST_BAD_ADDR    = 4'd15;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	// request queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	// one queued request, a snapshot of everything the back end needs
	typedef struct packed {
		req_kind_t  kind;
		logic [3:0] status;
		logic [8:0] flen;
		logic [7:0] hdr_slave;
		logic [7:0] hdr_func;
		logic [7:0] hdr_third;
		logic [7:0] exp_slave;
		logic [7:0] exp_func;
		logic [7:0] data;
	} req_t;

endpackage

/* design/mrc_ram.sv */
// generic single write port ram with registered read
module mrc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* design/mrc_front.sv */
// front end: request decode, receive phase, running crc, frame store
module mrc_front #(
	parameter int unsigned FRAME_BYTES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         cmd,
	input  logic [7:0]         arm_addr,
	input  logic [7:0]         arm_func,
	input  logic [7:0]         rx_byte,
	input  logic [7:0]         payload_index,
	output logic               req_valid,
	output mrc_pkg::req_t      req
);

	localparam int unsigned AW = $clog2(FRAME_BYTES);
	localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

	localparam logic [7:0]  MAX_SLAVE   = 8'd247;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [8:0]  PAYLOAD_OFS = 9'd3;
	localparam logic [CW-1:0] MIN_FRAME = CW'(4);

	// one byte of modbus crc16, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	mrc_pkg::phase_t phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic [15:0]   crc_q, crc_d;
	logic [7:0]    exp_slave_q, exp_slave_d;
	logic [7:0]    exp_func_q, exp_func_d;
	logic [7:0]    hdr0_q, hdr1_q, hdr2_q;

	logic [15:0]   crc_new;
	logic [CW-1:0] count_inc;
	logic [8:0]    offset;
	logic          wr_en;
	logic          push_d;
	logic          rd_ok_d;
	mrc_pkg::req_t req_d;

	logic          req_valid_s1;
	logic          rd_ok_s1;
	mrc_pkg::req_t req_s1;
	logic [7:0]    rd_data;

	assign crc_new   = crc_byte(crc_q, rx_byte);
	assign count_inc = count_q + CW'(1);
	assign offset    = {1'b0, payload_index} + PAYLOAD_OFS;

	// next state and request classification
	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		crc_d       = crc_q;
		exp_slave_d = exp_slave_q;
		exp_func_d  = exp_func_q;
		wr_en       = 1'b0;
		push_d      = 1'b0;
		rd_ok_d     = 1'b0;
		req_d           = '0;
		req_d.kind      = mrc_pkg::RK_STATUS;
		req_d.hdr_slave = hdr0_q;
		req_d.hdr_func  = hdr1_q;
		req_d.hdr_third = hdr2_q;
		req_d.exp_slave = exp_slave_q;
		req_d.exp_func  = exp_func_q;
		if (accept) begin
			unique case (mrc_pkg::cmd_t'(cmd))
				mrc_pkg::CMD_ARM: begin
					if (arm_addr == 8'd0 || arm_addr > MAX_SLAVE) begin
						phase_d      = mrc_pkg::PH_IDLE;
						push_d       = 1'b1;
						req_d.status = mrc_pkg::ST_BAD_ADDR;
					end else begin
						phase_d     = mrc_pkg::PH_RECV;
						count_d     = '0;
						crc_d       = CRC_INIT;
						exp_slave_d = arm_addr;
						exp_func_d  = arm_func;
					end
				end
				mrc_pkg::CMD_BYTE: begin
					if (phase_q == mrc_pkg::PH_RECV && count_q < CW'(FRAME_BYTES)) begin
						wr_en   = 1'b1;
						count_d = count_inc;
						crc_d   = crc_new;
						if (count_inc >= MIN_FRAME && crc_new == 16'h0000) begin
							phase_d    = mrc_pkg::PH_DONE;
							push_d     = 1'b1;
							req_d.kind = mrc_pkg::RK_CHECK;
							req_d.flen = 9'(count_inc);
						end else if (count_inc == CW'(FRAME_BYTES)) begin
							phase_d      = mrc_pkg::PH_DONE;
							push_d       = 1'b1;
							req_d.status = mrc_pkg::ST_CRC;
							req_d.flen   = 9'(count_inc);
						end
					end
				end
				mrc_pkg::CMD_TIMEOUT: begin
					if (phase_q == mrc_pkg::PH_RECV) begin
						phase_d      = mrc_pkg::PH_DONE;
						push_d       = 1'b1;
						req_d.status = (count_q == '0) ? mrc_pkg::ST_TIMEOUT : mrc_pkg::ST_CRC;
						req_d.flen   = 9'(count_q);
					end
				end
				mrc_pkg::CMD_READ: begin
					push_d     = 1'b1;
					req_d.kind = mrc_pkg::RK_DATA;
					rd_ok_d    = offset < 9'(count_q);
				end
				default: begin
				end
			endcase
		end
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mrc_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// frame counters and expected values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			crc_q       <= CRC_INIT;
			exp_slave_q <= '0;
			exp_func_q  <= '0;
		end else begin
			count_q     <= count_d;
			crc_q       <= crc_d;
			exp_slave_q <= exp_slave_d;
			exp_func_q  <= exp_func_d;
		end
	end

	// header bytes kept beside the store for the checker
	always_ff @(posedge clk) begin
		if (wr_en && count_q == CW'(0)) begin
			hdr0_q <= rx_byte;
		end
		if (wr_en && count_q == CW'(1)) begin
			hdr1_q <= rx_byte;
		end
		if (wr_en && count_q == CW'(2)) begin
			hdr2_q <= rx_byte;
		end
	end

	// frame store
	mrc_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (rx_byte),
		.rd_addr (offset[AW-1:0]),
		.rd_data (rd_data)
	);

	// stage 1: wait for the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else begin
			req_valid_s1 <= push_d;
		end
	end

	always_ff @(posedge clk) begin
		req_s1   <= req_d;
		rd_ok_s1 <= rd_ok_d;
	end

	// request to the queue, read data merged in
	always_comb begin
		req      = req_s1;
		req.data = rd_ok_s1 ? rd_data : 8'h00;
	end
	assign req_valid = req_valid_s1;

	// count never runs past the frame size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FRAME_BYTES))
		else $error("frame count past frame size");

	// an accepted byte in receive advances the count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_inc))
		else $error("byte not counted");

	// a frame check is only requested after at least four bytes
	a_check_len: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && req_s1.kind == mrc_pkg::RK_CHECK |-> req_s1.flen >= 9'd4)
		else $error("frame check on short frame");

endmodule

/* design/mrc_queue.sv */
// request queue between front and back
module mrc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mrc_pkg::req_t          push_req,
	input  logic                   pop,
	output logic                   not_empty,
	output mrc_pkg::req_t          head,
	output logic [mrc_pkg::Q_AW:0] level
);

	mrc_pkg::req_t mem_q [mrc_pkg::Q_DEPTH];
	logic [mrc_pkg::Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [mrc_pkg::Q_AW:0]   cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (mrc_pkg::Q_AW)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (mrc_pkg::Q_AW)'(1);
			end
			cnt_q <= cnt_q + (mrc_pkg::Q_AW + 1)'(push) - (mrc_pkg::Q_AW + 1)'(pop);
		end
	end

	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];
	assign level     = cnt_q;

	// the full signal of the top level reserves room, so a push always finds a free slot
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q < (mrc_pkg::Q_AW + 1)'(mrc_pkg::Q_DEPTH))
		else $error("request queue overflow");

	// the back end never takes from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("request queue underflow");

endmodule

/* design/mrc_back.sv */
// back end: frame checks and the result register
module mrc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  mrc_pkg::req_t q_req,
	output logic          q_pop,
	output logic          empty,
	input  logic          pop,
	output logic          result_kind,
	output logic [3:0]    status,
	output logic [8:0]    frame_length,
	output logic [7:0]    data_bytes,
	output logic [7:0]    payload_byte
);

	localparam logic [7:0] FUNC_MASK      = 8'h7F;
	localparam logic [7:0] FC_READ_FIRST  = 8'd1;
	localparam logic [7:0] FC_READ_INPUT  = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
	localparam logic [7:0] FC_WRITE_REG   = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS  = 8'd16;
	localparam logic [7:0] EXC_FIRST      = 8'd1;
	localparam logic [7:0] EXC_LAST       = 8'd6;
	localparam logic [7:0] EXC_GW_PATH    = 8'h0A;
	localparam logic [7:0] EXC_GW_TARGET  = 8'h0B;
	localparam logic [3:0] EXC_STATUS_OFS = 4'd5;
	localparam logic [8:0] READ_OVERHEAD  = 9'd5;
	localparam logic [8:0] WRITE_LEN      = 9'd8;

	logic       out_valid_q;
	logic       kind_d;
	logic [3:0] st_d;
	logic [8:0] flen_d;
	logic [7:0] bc_d;
	logic [7:0] pb_d;
	logic [3:0] chk_st;
	logic [7:0] chk_bc;

	// address, function, exception and length checks of a good frame
	always_comb begin
		chk_st = mrc_pkg::ST_OK;
		chk_bc = 8'h00;
		if (q_req.hdr_slave != q_req.exp_slave) begin
			chk_st = mrc_pkg::ST_SLAVE;
		end else if ((q_req.hdr_func & FUNC_MASK) != q_req.exp_func) begin
			chk_st = mrc_pkg::ST_FUNC;
		end else if (q_req.hdr_func[7]) begin
			case (q_req.hdr_third) inside
				[EXC_FIRST:EXC_LAST]: chk_st = q_req.hdr_third[3:0] + EXC_STATUS_OFS;
				EXC_GW_PATH:          chk_st = mrc_pkg::ST_EXC_0A;
				EXC_GW_TARGET:        chk_st = mrc_pkg::ST_EXC_0B;
				default:              chk_st = mrc_pkg::ST_EXC_UNKNOWN;
			endcase
		end else begin
			case (q_req.exp_func) inside
				[FC_READ_FIRST:FC_READ_INPUT]: begin
					if (q_req.flen < READ_OVERHEAD
							|| q_req.flen != READ_OVERHEAD + {1'b0, q_req.hdr_third}) begin
						chk_st = mrc_pkg::ST_LENGTH;
					end else begin
						chk_bc = q_req.hdr_third;
					end
				end
				FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
					chk_st = (q_req.flen == WRITE_LEN) ? mrc_pkg::ST_OK : mrc_pkg::ST_LENGTH;
				end
				default: chk_st = mrc_pkg::ST_LENGTH;
			endcase
		end
	end

	// result fields by request kind
	always_comb begin
		kind_d = mrc_pkg::KIND_STATUS;
		st_d   = q_req.status;
		flen_d = q_req.flen;
		bc_d   = 8'h00;
		pb_d   = 8'h00;
		unique case (q_req.kind)
			mrc_pkg::RK_STATUS: begin
			end
			mrc_pkg::RK_CHECK: begin
				st_d = chk_st;
				bc_d = chk_bc;
			end
			mrc_pkg::RK_DATA: begin
				kind_d = mrc_pkg::KIND_DATA;
				st_d   = mrc_pkg::ST_OK;
				flen_d = 9'd0;
				pb_d   = q_req.data;
			end
			default: begin
			end
		endcase
	end

	// load the result register when it is free or being taken
	assign q_pop = q_valid && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			result_kind  <= kind_d;
			status       <= st_d;
			frame_length <= flen_d;
			data_bytes   <= bc_d;
			payload_byte <= pb_d;
		end
	end

	assign empty = !out_valid_q;

	// a read data result carries no status and no length
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_kind == mrc_pkg::KIND_DATA |-> status == mrc_pkg::ST_OK
			&& frame_length == 9'd0 && data_bytes == 8'h00)
		else $error("payload result with status fields");

	// a byte count is only reported with status ok
	a_bc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && data_bytes != 8'h00 |-> status == mrc_pkg::ST_OK)
		else $error("byte count on failed frame");

	// a held result is not replaced while it waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(status) && $stable(payload_byte))
		else $error("waiting result changed");

endmodule

/* design/modbus_rtu_response_checker.sv */
// modbus rtu master response checker, top level
// a result passes the store read stage, the request queue and the result register in order
//   on its way to the result ports when nothing waits ahead
// throughput: one request per cycle while full is low; full rises once the 4-entry request queue
//   plus the request in the store read stage would fill it
// reset: arst_n clears phase, counters, crc, expected values and queues at once;
//   the frame store has no reset, reads are limited to bytes of the current frame
module modbus_rtu_response_checker #(
	parameter int unsigned FRAME_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [7:0] arm_addr,
	input  logic [7:0] arm_func,
	input  logic [7:0] rx_byte,
	input  logic [7:0] payload_index,
	output logic       empty,
	input  logic       pop,
	output logic       result_kind,
	output logic [3:0] status,
	output logic [8:0] frame_length,
	output logic [7:0] data_bytes,
	output logic [7:0] payload_byte
);

	localparam int unsigned LW = mrc_pkg::Q_AW + 2;

	logic                   accept;
	logic                   req_valid;
	mrc_pkg::req_t          req;
	logic                   q_valid;
	logic                   q_pop;
	mrc_pkg::req_t          q_head;
	logic [mrc_pkg::Q_AW:0] q_level;

	// room for the request in flight plus the queued ones
	assign full   = (LW'(q_level) + LW'(req_valid)) >= LW'(mrc_pkg::Q_DEPTH);
	assign accept = push && !full;

	mrc_front #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cmd           (cmd),
		.arm_addr      (arm_addr),
		.arm_func      (arm_func),
		.rx_byte       (rx_byte),
		.payload_index (payload_index),
		.req_valid     (req_valid),
		.req           (req)
	);

	mrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_valid),
		.push_req  (req),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head),
		.level     (q_level)
	);

	mrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_req        (q_head),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.status       (status),
		.frame_length (frame_length),
		.data_bytes   (data_bytes),
		.payload_byte (payload_byte)
	);

endmodule
